[src/efce_pkg.sv]
// Shared types, constants and CRC function for the escaped frame CRC encoder.
`timescale 1ns / 1ps

package efce_pkg;

    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  ESC_BYTE   = 8'hF0;
    localparam logic [7:0]  LOW_NIBBLE = 8'h0F;
    localparam logic [7:0]  END_BYTE   = 8'hF6;

    // One classified message byte, as handed from the front to the back
    typedef struct packed {
        logic [7:0]  data;
        logic        raw;        // header byte: never escaped
        logic        last;       // final byte of the message
        logic        want_crc;   // on the final byte: append CRC bytes after it
        logic [15:0] crc;        // running CRC including this byte
    } efce_cmd_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } efce_qstat_t;

    // Which wire byte of the current command the back is producing
    typedef enum logic [1:0] {
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_END
    } efce_phase_t;

    // Reflected CRC-16 update over one byte, one shift per bit
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[src/escaped_frame_crc_encoder.sv]
// Top level of the escaped frame CRC encoder.
//
// Input channel (in_valid / in_stall): one unescaped message byte per
// transaction, header first, with end_of_message on the final byte and
// append_checksum sampled with it. A reflected CRC-16 (poly A001, init 0)
// runs over every message byte. Output channel (out_valid / out_stall): one
// escaped wire byte per transaction; frame_end marks the closing F6 byte.
// The first wire byte of an input byte passes through the queue and then the
// output register of the back-end sequencer. Throughput is one wire byte per
// cycle while the receiver does not stall and the queue is not empty: an input
// byte gives 1 wire byte, or 2 if escaped; a final byte adds 1 end byte, or 3
// to 5 bytes with the CRC bytes (up to 7 wire bytes in all).
// A queue of QUEUE_DEPTH classified bytes parts the front end from the back
// end; when the receiver stalls, the output byte holds, the queue fills, and
// in_stall rises once the queue is full.
// Reset clears the CRC to 0, expects a header next, empties the queue and
// drops out_valid.
`timescale 1ns / 1ps

module escaped_frame_crc_encoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    input  logic       append_checksum,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       frame_end
);

    efce_pkg::efce_qstat_t qstat;
    efce_pkg::efce_cmd_t   push_cmd;
    efce_pkg::efce_cmd_t   head_cmd;
    logic                  push;
    logic                  pop;

    efce_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .end_of_message  (end_of_message),
        .append_checksum (append_checksum),
        .qstat           (qstat),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    efce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    efce_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

endmodule

[src/efce_front.sv]
// Front end: accepts message bytes, runs the CRC and classifies each byte.
`timescale 1ns / 1ps

module efce_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                end_of_message,
    input  logic                append_checksum,
    input  efce_pkg::efce_qstat_t qstat,
    output logic                push,
    output efce_pkg::efce_cmd_t push_cmd
);

    logic [15:0] running_crc_reg;
    logic [15:0] running_crc_next;
    logic        expect_header_reg;
    logic        expect_header_next;
    logic [15:0] crc_new;

    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;
    assign crc_new  = efce_pkg::crc_update(running_crc_reg, data_byte);

    // Command built from the incoming transaction
    always_comb
    begin
        push_cmd.data     = data_byte;
        push_cmd.raw      = expect_header_reg;
        push_cmd.last     = end_of_message;
        push_cmd.want_crc = append_checksum;
        push_cmd.crc      = crc_new;
    end

    // Message state: CRC and header flag restart after the final byte
    always_comb
    begin
        running_crc_next   = running_crc_reg;
        expect_header_next = expect_header_reg;
        if (push)
        begin
            if (end_of_message)
            begin
                running_crc_next   = 16'h0000;
                expect_header_next = 1'b1;
            end
            else
            begin
                running_crc_next   = crc_new;
                expect_header_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg   <= 16'h0000;
            expect_header_reg <= 1'b1;
        end
        else
        begin
            running_crc_reg   <= running_crc_next;
            expect_header_reg <= expect_header_next;
        end
    end

    a_msg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (push && end_of_message) |=> (expect_header_reg && running_crc_reg == 16'h0000))
        else $error("message state not restarted after final byte");

endmodule

[src/efce_queue.sv]
// Small command queue between the front end and the back end.
`timescale 1ns / 1ps

module efce_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  efce_pkg::efce_cmd_t   push_cmd,
    input  logic                  pop,
    output efce_pkg::efce_cmd_t   head_cmd,
    output efce_pkg::efce_qstat_t qstat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    efce_pkg::efce_cmd_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign qstat.full  = (count_reg == DEPTH_CNT);
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_cmd    = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule

[src/efce_back.sv]
// Back end: expands queued commands into escaped wire bytes.
`timescale 1ns / 1ps

module efce_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  efce_pkg::efce_cmd_t   head_cmd,
    input  efce_pkg::efce_qstat_t qstat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  frame_end
);

    efce_pkg::efce_phase_t phase_reg;
    efce_pkg::efce_phase_t phase_next;
    logic       esc_pending_reg;
    logic       esc_pending_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       frame_end_reg;
    logic       frame_end_next;
    logic       load;
    logic [7:0] cur_byte;
    logic       escapable;

    assign load = !qstat.empty && (!out_valid_reg || !out_stall);

    // Sequencer: one wire byte per load
    always_comb
    begin
        phase_next       = phase_reg;
        esc_pending_next = esc_pending_reg;
        out_byte_next    = out_byte_reg;
        frame_end_next   = frame_end_reg;
        pop              = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;

        case (phase_reg)
            efce_pkg::PH_DATA:   cur_byte = head_cmd.data;
            efce_pkg::PH_CRC_LO: cur_byte = head_cmd.crc[7:0];
            efce_pkg::PH_CRC_HI: cur_byte = head_cmd.crc[15:8];
            efce_pkg::PH_END:    cur_byte = efce_pkg::END_BYTE;
            default:             cur_byte = head_cmd.data;
        endcase

        escapable = (phase_reg != efce_pkg::PH_END)
                 && !(phase_reg == efce_pkg::PH_DATA && head_cmd.raw)
                 && ((cur_byte & efce_pkg::ESC_BYTE) == efce_pkg::ESC_BYTE);

        if (load)
        begin
            out_valid_next = 1'b1;
            frame_end_next = (phase_reg == efce_pkg::PH_END);
            if (escapable && !esc_pending_reg)
            begin
                // first half of an escape pair
                out_byte_next    = efce_pkg::ESC_BYTE;
                esc_pending_next = 1'b1;
            end
            else
            begin
                out_byte_next    = esc_pending_reg ? (cur_byte & efce_pkg::LOW_NIBBLE)
                                                   : cur_byte;
                esc_pending_next = 1'b0;
                case (phase_reg)
                    efce_pkg::PH_DATA:
                    begin
                        if (!head_cmd.last)
                            pop = 1'b1;
                        else if (head_cmd.want_crc)
                            phase_next = efce_pkg::PH_CRC_LO;
                        else
                            phase_next = efce_pkg::PH_END;
                    end
                    efce_pkg::PH_CRC_LO: phase_next = efce_pkg::PH_CRC_HI;
                    efce_pkg::PH_CRC_HI: phase_next = efce_pkg::PH_END;
                    efce_pkg::PH_END:
                    begin
                        pop        = 1'b1;
                        phase_next = efce_pkg::PH_DATA;
                    end
                    default:   phase_next = efce_pkg::PH_DATA;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= efce_pkg::PH_DATA;
            esc_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            esc_pending_reg <= esc_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output payload holds while stalled
    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        frame_end_reg <= frame_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |-> (out_byte_reg == efce_pkg::END_BYTE))
        else $error("frame end flag on a byte other than the end byte");

    a_esc_low: assert property (@(posedge clk) disable iff (!rst_n)
        (load && esc_pending_reg) |=> (out_byte_reg[7:4] == 4'h0 && !frame_end_reg))
        else $error("escape pair second half is not a low nibble");

endmodule

[tb/sv/escaped_frame_crc_encoder_tb.sv]
// Self-checking testbench for the escaped frame CRC encoder: byte-level predictor and scoreboard.
`timescale 1ns / 1ps

module escaped_frame_crc_encoder_tb;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int LONG_HOLD_CYCLES = 300;

    // One expected wire byte
    typedef struct packed {
        logic [7:0] value;
        logic       is_end;
    } wire_byte_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_mode_t;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       in_valid        = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte       = 8'h00;
    logic       end_of_message  = 1'b0;
    logic       append_checksum = 1'b0;
    logic       out_valid;
    logic       out_stall       = 1'b0;
    logic [7:0] out_byte;
    logic       frame_end;

    escaped_frame_crc_encoder u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .end_of_message  (end_of_message),
        .append_checksum (append_checksum),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .frame_end       (frame_end)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state and the wire bytes still owed by the block
    logic [15:0] msg_crc   = 16'h0000;
    logic        at_header = 1'b1;
    wire_byte_t  pending_wire_q[$];
    int          mismatch_count = 0;

    // Handshake samples taken mid-cycle, acted on at the next rising edge
    logic        in_fire_s   = 1'b0;
    logic        out_fire_s  = 1'b0;
    logic [7:0]  out_byte_s  = 8'h00;
    logic        frame_end_s = 1'b0;

    // Receiver and sender pacing
    stall_mode_t stall_mode    = STALL_NONE;
    int          long_hold_req = 0;
    int          hold_left     = 0;
    int          stall_phase   = 0;
    logic        sender_bursty = 1'b0;
    int          burst_left    = 0;

    // Reflected CRC-16, fed one input bit at a time, LSB first
    function automatic logic [15:0] crc16_arc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ efce_pkg::CRC_POLY;
        end
        return c;
    endfunction

    // Payload byte with a bias toward the escaped range
    function automatic logic [7:0] rand_msg_byte();
        if ($urandom_range(0, 9) < 3)
            return {4'hF, 4'($urandom_range(0, 15))};
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Append one expected wire byte to the scoreboard
    task automatic expect_wire(input logic [7:0] v, input logic e);
        wire_byte_t w;
        w.value        = v;
        w.is_end       = e;
        pending_wire_q = {pending_wire_q, w};
    endtask

    task automatic push_escaped(input logic [7:0] b);
        if ((b & efce_pkg::ESC_BYTE) == efce_pkg::ESC_BYTE)
        begin
            expect_wire(efce_pkg::ESC_BYTE, 1'b0);
            expect_wire(b & efce_pkg::LOW_NIBBLE, 1'b0);
        end
        else
            expect_wire(b, 1'b0);
    endtask

    // Expected wire bytes for one accepted message byte
    task automatic predict_wire_bytes(input logic [7:0] b, input logic eom, input logic want_crc);
        msg_crc = crc16_arc_next(msg_crc, b);
        if (at_header)
        begin
            expect_wire(b, 1'b0);
            at_header = 1'b0;
        end
        else
            push_escaped(b);
        if (eom)
        begin
            if (want_crc)
            begin
                push_escaped(msg_crc[7:0]);
                push_escaped(msg_crc[15:8]);
            end
            expect_wire(efce_pkg::END_BYTE, 1'b1);
            msg_crc   = 16'h0000;
            at_header = 1'b1;
        end
    endtask

    // Sample both channels where every signal is settled
    always @(negedge clk)
    begin
        in_fire_s   = in_valid && !in_stall;
        out_fire_s  = out_valid && !out_stall;
        out_byte_s  = out_byte;
        frame_end_s = frame_end;
    end

    // Compare each accepted wire byte with the oldest expectation
    always @(posedge clk)
    begin
        wire_byte_t exp_b;
        if (out_fire_s)
        begin
            if (pending_wire_q.size() == 0)
                report_mismatch($sformatf("unexpected wire byte %02h end %0b",
                                          out_byte_s, frame_end_s));
            else
            begin
                exp_b = pending_wire_q.pop_front();
                if (out_byte_s !== exp_b.value)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte_s, exp_b.value));
                if (frame_end_s !== exp_b.is_end)
                    report_mismatch($sformatf("frame_end %0b, expected %0b (byte %02h)",
                                              frame_end_s, exp_b.is_end, exp_b.value));
            end
        end
    end

    // Receiver stall generator; a long hold overrides the current pattern
    always @(posedge clk)
    begin
        if (long_hold_req != 0)
        begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:
                    out_stall <= 1'b0;
                STALL_RANDOM:
                    out_stall <= ($urandom_range(0, 2) == 0);
                STALL_PERIODIC:
                begin
                    out_stall   <= (stall_phase < 3);
                    stall_phase = (stall_phase + 1) % 7;
                end
                default:
                    out_stall <= 1'b0;
            endcase
        end
    end

    // Watchdog: ends the run when no transaction happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (in_fire_s || out_fire_s)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one message byte; called and returns at a rising edge
    task automatic send_byte(input logic [7:0] b, input logic eom, input logic want_crc);
        int gap;
        if (sender_bursty && burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid        <= 1'b1;
        data_byte       <= b;
        end_of_message  <= eom;
        append_checksum <= want_crc;
        do
            @(negedge clk);
        while (in_stall !== 1'b0);
        predict_wire_bytes(b, eom, want_crc);
        @(posedge clk);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One whole message; stray checksum flags may sit on non-final bytes
    task automatic send_message(input int len, input logic want_crc, input logic stray_flags);
        int   i;
        logic last;
        logic flag;
        for (i = 0; i < len; i++)
        begin
            last = (i == len - 1);
            if (last)
                flag = want_crc;
            else
                flag = stray_flags ? 1'($urandom_range(0, 1)) : 1'b0;
            send_byte(rand_msg_byte(), last, flag);
        end
    endtask

    // Extremes, header-only frames, escapes and a worst-case expansion
    task automatic test_directed();
        int         h;
        int         p;
        logic [7:0] worst_hdr;
        logic [7:0] worst_pay;
        logic [15:0] c;
        worst_hdr = 8'h00;
        worst_pay = 8'hF0;
        // find a two-byte message whose payload and both CRC bytes are escaped
        for (h = 0; h < 256; h++)
            for (p = 8'hF0; p < 256; p++)
            begin
                c = crc16_arc_next(crc16_arc_next(16'h0000, 8'(h)), 8'(p));
                if (c[7:4] == 4'hF && c[15:12] == 4'hF)
                begin
                    worst_hdr = 8'(h);
                    worst_pay = 8'(p);
                end
            end
        stall_mode    = STALL_NONE;
        sender_bursty = 1'b0;
        // header alone closes the frame; an F-nibble header stays raw
        send_byte(8'hF5, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        // field extremes and every escape boundary, stray checksum flags
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hF0, 1'b0, 1'b0);
        send_byte(8'h0F, 1'b0, 1'b1);
        send_byte(8'hEF, 1'b0, 1'b0);
        send_byte(8'hF6, 1'b1, 1'b1);
        // plain message without checksum
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'hFA, 1'b1, 1'b0);
        // seven wire bytes from one input byte
        send_byte(worst_hdr, 1'b0, 1'b0);
        send_byte(worst_pay, 1'b1, 1'b1);
        stop_sending();
    endtask

    // Random messages under bursty input and the given output stall pattern
    task automatic test_random_messages(input int n_items, input stall_mode_t mode);
        int sent;
        int len;
        stall_mode    = mode;
        sender_bursty = 1'b1;
        burst_left    = 0;
        sent          = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            send_message(len, 1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)));
            sent += len;
        end
        stop_sending();
    endtask

    // Receiver holds off for a long stretch while input keeps coming
    task automatic test_long_hold();
        int sent;
        int len;
        stall_mode    = STALL_NONE;
        sender_bursty = 1'b0;
        @(negedge clk);
        long_hold_req = LONG_HOLD_CYCLES;
        @(posedge clk);
        sent = 0;
        while (sent < 40)
        begin
            len = $urandom_range(1, 10);
            send_message(len, 1'b1, 1'b0);
            sent += len;
        end
        stop_sending();
    endtask

    // Back-to-back input, no receiver stalls
    task automatic test_full_rate();
        int sent;
        int len;
        stall_mode    = STALL_NONE;
        sender_bursty = 1'b0;
        sent          = 0;
        while (sent < 50)
        begin
            len = $urandom_range(1, 8);
            send_message(len, 1'($urandom_range(0, 1)), 1'b1);
            sent += len;
        end
        stop_sending();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_messages(150, STALL_RANDOM);
        test_long_hold();
        test_full_rate();
        test_random_messages(100, STALL_PERIODIC);

        // drain, then allow time for any stray extra byte to show up
        while (pending_wire_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
src/efce_pkg.sv
src/efce_front.sv
src/efce_queue.sv
src/efce_back.sv
src/escaped_frame_crc_encoder.sv
tb/sv/escaped_frame_crc_encoder_tb.sv
